/* hdl/grid_rectangle_occupancy_allocator_unit_assert.svh */
// Assertion macros for the grid rectangle occupancy allocator.
`ifndef GRID_RECTANGLE_OCCUPANCY_ALLOCATOR_UNIT_ASSERT_SVH
`define GRID_RECTANGLE_OCCUPANCY_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define GROA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define GROA_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define GROA_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define GROA_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/groa_pkg.sv */
// Shared types and constants of the grid rectangle occupancy allocator.
`timescale 1ns / 1ps
`default_nettype none
package groa_pkg;
	localparam int MAX_WIDTH_DEF    = 16;
	localparam int MAX_HEIGHT_DEF   = 16;
	localparam int ITEM_ID_BITS_DEF = 16;

	// coordinates, spans and sums of both stay below 128
	localparam int DIM_W  = 7;
	localparam int SPAN_W = 5;
	localparam int RUN_W  = 5;
	localparam int ID_W   = 16;

	typedef logic [DIM_W-1:0] dim_t;

	localparam logic [SPAN_W-1:0] GRID_RESET = 5'd16;

	typedef enum logic {
		CFG_GRID_WIDTH  = 1'b0,
		CFG_GRID_HEIGHT = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		OP_FIT     = 3'd0,
		OP_FIND    = 3'd1,
		OP_MARK    = 3'd2,
		OP_UNMARK  = 3'd3,
		OP_REPLACE = 3'd4,
		OP_QUERY   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PREP,
		ST_WALK,
		ST_LOOK
	} st_t;
endpackage
`default_nettype wire

/* hdl/groa_row_store.sv */
// Row memory of the occupancy and origin valid bits, with per-row valid flags.
`timescale 1ns / 1ps
`default_nettype none
module groa_row_store #(
	parameter int ROWS   = 16,
	parameter int ADDR_W = 4,
	parameter int WORD_W = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 rd_en,
	input  wire logic [ADDR_W-1:0]    rd_addr,
	output logic      [WORD_W-1:0]    rd_data,
	input  wire logic                 wr_en,
	input  wire logic [ADDR_W-1:0]    wr_addr,
	input  wire logic [WORD_W-1:0]    wr_data
);
	logic [WORD_W-1:0] mem [ROWS];
	logic [ROWS-1:0]   row_init_q;

	// a row never written reads as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_init_q <= '0;
		end else if (wr_en) begin
			row_init_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= row_init_q[rd_addr] ? mem[rd_addr] : '0;
		end
	end
endmodule
`default_nettype wire

/* hdl/groa_item_store.sv */
// Memory of the item identifiers recorded at origin cells.
`timescale 1ns / 1ps
`default_nettype none
module groa_item_store #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 16
) (
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] addr,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic      [DATA_W-1:0] rd_data
);
	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[addr];
		end
	end
endmodule
`default_nettype wire

/* hdl/grid_rectangle_occupancy_allocator_unit.sv */
// Top level of the grid rectangle occupancy allocator.
//
//  channel   | handshake            | payload
//  ----------+----------------------+---------------------------------------------
//  command   | start / busy         | opcode pos_x pos_y span_x span_y item_id
//  result    | done (one cycle)     | ok found_x found_y item_present item_at_cell
//  config    | cfg_valid/cfg_ready  | cfg_index cfg_data
//
// An item walks the row memory one row per cycle; the rows visited are the span
// height for a fit check (one row for a zero span) or a mark (clipped to the grid,
// one row when nothing is painted), and the rows up to the hit or the active
// height for find-first. Query and replace check read one row with no walk. A fit
// check that fails the bounds test, find-first on an empty grid and an unused
// opcode finish from the prep state with no walk.
// Reset clears the per-row valid flags at once; there is no clearing pass.
// busy is high from acceptance to the done cycle and config writes wait for it to
// drop; results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_rectangle_occupancy_allocator_unit_assert.svh"
module grid_rectangle_occupancy_allocator_unit #(
	parameter int MAX_WIDTH    = groa_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT   = groa_pkg::MAX_HEIGHT_DEF,
	parameter int ITEM_ID_BITS = groa_pkg::ITEM_ID_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [3:0]  pos_x,
	input  wire logic [3:0]  pos_y,
	input  wire logic [4:0]  span_x,
	input  wire logic [4:0]  span_y,
	input  wire logic [15:0] item_id,
	output logic             done,
	output logic             ok,
	output logic [3:0]       found_x,
	output logic [3:0]       found_y,
	output logic             item_present,
	output logic [15:0]      item_at_cell,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [4:0]  cfg_data
);
	localparam int DIM_W  = groa_pkg::DIM_W;
	localparam int RUN_W  = groa_pkg::RUN_W;
	localparam int ID_W   = groa_pkg::ID_W;
	localparam int RA_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CA_W   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WORD_W = 2 * MAX_WIDTH;
	localparam int WIN_W  = 32;
	localparam groa_pkg::dim_t MAXW_D = DIM_W'(MAX_WIDTH);
	localparam groa_pkg::dim_t MAXH_D = DIM_W'(MAX_HEIGHT);
	localparam groa_pkg::dim_t ONE_D  = DIM_W'(1);

	groa_pkg::st_t state_q, state_d;
	groa_pkg::op_t op_q;
	groa_pkg::dim_t x_q, y_q, sx_q, sy_q;
	logic [ID_W-1:0] id_q;
	logic [4:0] gw_q, gh_q;

	// walker
	groa_pkg::dim_t row_q, left_q, row_s1, pend_q;
	logic v_s1, last_s1, any_q;
	logic [MAX_WIDTH-1:0] cm_q, cm_d;
	logic [RUN_W-1:0] run_q [MAX_WIDTH];
	logic [RUN_W-1:0] run_new [MAX_WIDTH];

	// result registers
	logic done_q, ok_q, pres_q;
	logic [3:0] fx_q, fy_q;
	logic [15:0] item_q;

	// per-item derived values
	groa_pkg::dim_t aw, ah, sxe, sye, pend, xend;
	logic zero, x_in, y_in, paint, fit_pre;

	logic fin, res_ok, res_pres;
	logic [3:0] res_fx, res_fy;
	logic [15:0] res_item;
	logic load_walk;
	groa_pkg::dim_t walk_start, walk_n, rd_row;

	logic row_re, row_we, item_re, item_we;
	logic [WORD_W-1:0] row_rdata, row_wdata;
	logic [MAX_WIDTH-1:0] occ, vld, occ_new, vld_new, okv, win;
	logic [MAX_WIDTH+WIN_W-1:0] okx;
	logic [WIN_W-1:0] smask;
	logic any_new, found;
	groa_pkg::dim_t found_c, found_r;
	logic [ITEM_ID_BITS-1:0] item_wdata, item_rdata;
	logic [15:0] item_rd16;
	logic [CA_W-1:0] xi;

	function automatic logic [MAX_WIDTH-1:0] col_mask(groa_pkg::dim_t lo, groa_pkg::dim_t hi);
		logic [MAX_WIDTH-1:0] m;
		for (int c = 0; c < MAX_WIDTH; c++) begin
			m[c] = (DIM_W'(c) >= lo) && (DIM_W'(c) < hi);
		end
		return m;
	endfunction

	assign busy      = (state_q != groa_pkg::ST_IDLE);
	assign cfg_ready = !busy;
	assign done         = done_q;
	assign ok           = ok_q;
	assign found_x      = fx_q;
	assign found_y      = fy_q;
	assign item_present = pres_q;
	assign item_at_cell = item_q;

	assign occ = row_rdata[MAX_WIDTH-1:0];
	assign vld = row_rdata[WORD_W-1:MAX_WIDTH];
	assign xi  = x_q[CA_W-1:0];

	// geometry of the current item
	always_comb begin
		aw = ({2'b0, gw_q} < MAXW_D) ? {2'b0, gw_q} : MAXW_D;
		ah = ({2'b0, gh_q} < MAXH_D) ? {2'b0, gh_q} : MAXH_D;
		zero = (sx_q == '0) || (sy_q == '0);
		sxe = zero ? ONE_D : sx_q;
		sye = zero ? ONE_D : sy_q;
		x_in = x_q < MAXW_D;
		y_in = y_q < MAXH_D;
		paint = !zero && (x_q < aw) && (y_q < ah);
		pend = paint ? (((y_q + sy_q) < ah) ? (y_q + sy_q) : ah) : y_q;
		xend = ((x_q + sx_q) < aw) ? (x_q + sx_q) : aw;
		fit_pre = ((x_q + sxe) <= aw) && ((y_q + sye) <= ah);
	end

	// row processing at the memory output
	always_comb begin
		any_new = any_q | (|(occ & cm_q));
		occ_new = occ;
		if (row_s1 < pend_q) begin
			occ_new = (op_q == groa_pkg::OP_MARK) ? (occ | cm_q) : (occ & ~cm_q);
		end
		vld_new = vld;
		if (row_s1 == y_q && x_in) begin
			vld_new[xi] = (op_q == groa_pkg::OP_MARK);
		end
		for (int c = 0; c < MAX_WIDTH; c++) begin
			run_new[c] = (!occ[c] && (DIM_W'(c) < aw)) ? run_q[c] + 1'b1 : '0;
			okv[c] = DIM_W'(run_new[c]) >= sye;
		end
		for (int k = 0; k < WIN_W; k++) begin
			smask[k] = DIM_W'(k) < sxe;
		end
		okx = {{WIN_W{1'b0}}, okv};
		for (int i = 0; i < MAX_WIDTH; i++) begin
			win[i] = &(okx[i +: WIN_W] | ~smask);
		end
		found = |win;
		found_c = '0;
		for (int i = MAX_WIDTH - 1; i >= 0; i--) begin
			if (win[i]) begin
				found_c = DIM_W'(i);
			end
		end
		found_r = row_s1 - sye + ONE_D;
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		fin = 1'b0;
		res_ok = 1'b0;
		res_fx = '0;
		res_fy = '0;
		res_pres = 1'b0;
		res_item = '0;
		load_walk = 1'b0;
		walk_start = '0;
		walk_n = '0;
		cm_d = cm_q;
		row_re = 1'b0;
		rd_row = row_q;
		row_we = 1'b0;
		item_re = 1'b0;
		item_we = 1'b0;
		case (state_q)
			groa_pkg::ST_IDLE: begin
				if (start) begin
					state_d = groa_pkg::ST_PREP;
				end
			end
			groa_pkg::ST_PREP: begin
				case (op_q)
					groa_pkg::OP_FIT: begin
						if (fit_pre) begin
							load_walk = 1'b1;
							walk_start = y_q;
							walk_n = sye;
							cm_d = col_mask(x_q, x_q + sxe);
						end else begin
							fin = 1'b1;
						end
					end
					groa_pkg::OP_FIND: begin
						if (aw != '0 && ah != '0) begin
							load_walk = 1'b1;
							walk_n = ah;
						end else begin
							fin = 1'b1;
						end
					end
					groa_pkg::OP_MARK, groa_pkg::OP_UNMARK: begin
						item_we = (op_q == groa_pkg::OP_MARK) && x_in && y_in;
						if (y_in) begin
							load_walk = 1'b1;
							walk_start = y_q;
							walk_n = paint ? (pend - y_q) : ONE_D;
							cm_d = col_mask(x_q, xend);
						end else begin
							fin = 1'b1;
							res_ok = 1'b1;
						end
					end
					groa_pkg::OP_REPLACE, groa_pkg::OP_QUERY: begin
						if (x_in && y_in) begin
							row_re = 1'b1;
							rd_row = y_q;
							item_re = 1'b1;
							state_d = groa_pkg::ST_LOOK;
						end else begin
							fin = 1'b1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
				if (load_walk) begin
					state_d = groa_pkg::ST_WALK;
				end
			end
			groa_pkg::ST_WALK: begin
				row_re = (left_q != '0);
				if (v_s1) begin
					case (op_q)
						groa_pkg::OP_FIT: begin
							if (last_s1) begin
								fin = 1'b1;
								res_ok = !any_new;
							end
						end
						groa_pkg::OP_FIND: begin
							if (found) begin
								fin = 1'b1;
								res_ok = 1'b1;
								res_fx = found_c[3:0];
								res_fy = found_r[3:0];
							end else if (last_s1) begin
								fin = 1'b1;
							end
						end
						groa_pkg::OP_MARK, groa_pkg::OP_UNMARK: begin
							row_we = 1'b1;
							if (last_s1) begin
								fin = 1'b1;
								res_ok = 1'b1;
							end
						end
						default: begin
							fin = 1'b1;
						end
					endcase
				end
			end
			groa_pkg::ST_LOOK: begin
				fin = 1'b1;
				if (op_q == groa_pkg::OP_REPLACE) begin
					res_ok = vld[xi] && (x_q < aw) && (y_q < ah)
						&& (zero ? !occ[xi] : fit_pre);
				end else begin
					res_pres = vld[xi];
					res_item = vld[xi] ? item_rd16 : '0;
				end
			end
			default: begin
				state_d = groa_pkg::ST_IDLE;
			end
		endcase
		if (fin) begin
			state_d = groa_pkg::ST_IDLE;
		end
	end

	assign row_wdata = {vld_new, occ_new};

	// identifier width conversion to and from the store
	assign item_wdata = ITEM_ID_BITS'(id_q);
	assign item_rd16  = ID_W'(item_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= groa_pkg::ST_IDLE;
			gw_q <= groa_pkg::GRID_RESET;
			gh_q <= groa_pkg::GRID_RESET;
			done_q <= 1'b0;
			left_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= fin;
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == groa_pkg::CFG_GRID_WIDTH) begin
					gw_q <= cfg_data;
				end else begin
					gh_q <= cfg_data;
				end
			end
			v_s1 <= (state_q == groa_pkg::ST_WALK) && (left_q != '0);
			if (load_walk) begin
				left_q <= walk_n;
			end else if (state_q == groa_pkg::ST_WALK && left_q != '0) begin
				left_q <= left_q - ONE_D;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= groa_pkg::op_t'(opcode);
			x_q  <= {3'b0, pos_x};
			y_q  <= {3'b0, pos_y};
			sx_q <= {2'b0, span_x};
			sy_q <= {2'b0, span_y};
			id_q <= item_id;
		end
		cm_q <= cm_d;
		last_s1 <= (left_q == ONE_D);
		row_s1 <= row_q;
		if (load_walk) begin
			row_q <= walk_start;
			pend_q <= pend;
			any_q <= 1'b0;
			for (int c = 0; c < MAX_WIDTH; c++) begin
				run_q[c] <= '0;
			end
		end else begin
			if (state_q == groa_pkg::ST_WALK && left_q != '0) begin
				row_q <= row_q + ONE_D;
			end
			if (v_s1) begin
				any_q <= any_new;
				for (int c = 0; c < MAX_WIDTH; c++) begin
					run_q[c] <= run_new[c];
				end
			end
		end
		if (fin) begin
			ok_q <= res_ok;
			fx_q <= res_fx;
			fy_q <= res_fy;
			pres_q <= res_pres;
			item_q <= res_item;
		end
	end

	groa_row_store #(
		.ROWS   (MAX_HEIGHT),
		.ADDR_W (RA_W),
		.WORD_W (WORD_W)
	) u_rows (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (row_re),
		.rd_addr (rd_row[RA_W-1:0]),
		.rd_data (row_rdata),
		.wr_en   (row_we),
		.wr_addr (row_s1[RA_W-1:0]),
		.wr_data (row_wdata)
	);

	groa_item_store #(
		.ADDR_W (RA_W + CA_W),
		.DATA_W (ITEM_ID_BITS)
	) u_items (
		.clk     (clk),
		.rd_en   (item_re),
		.wr_en   (item_we),
		.addr    ({y_q[RA_W-1:0], xi}),
		.wr_data (item_wdata),
		.rd_data (item_rdata)
	);

	`GROA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`GROA_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)
	`GROA_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`GROA_ASSERT_IMP(a_write_walk, clk, arst_n, row_we, state_q == groa_pkg::ST_WALK)
endmodule
`default_nettype wire

/* sim/tb_grid_rectangle_occupancy_allocator_unit.sv */
// Testbench for the grid rectangle occupancy allocator: directed table, then random items.
`timescale 1ns / 1ps
module tb_grid_rectangle_occupancy_allocator_unit;
	typedef struct packed {
		logic        ok;
		logic [3:0]  fx;
		logic [3:0]  fy;
		logic        pres;
		logic [15:0] item;
	} grid_result_t;

	typedef struct packed {
		groa_pkg::op_t op;
		logic [3:0]  px;
		logic [3:0]  py;
		logic [4:0]  sx;
		logic [4:0]  sy;
		logic [15:0] id;
	} grid_cmd_t;

	typedef struct packed {
		grid_cmd_t    cmd;
		logic         typed;
		grid_result_t res;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [2:0] opcode = '0;
	logic [3:0] pos_x = '0;
	logic [3:0] pos_y = '0;
	logic [4:0] span_x = '0;
	logic [4:0] span_y = '0;
	logic [15:0] item_id = '0;
	logic cfg_valid = 1'b0;
	logic cfg_index = 1'b0;
	logic [4:0] cfg_data = '0;
	logic busy, done, ok, item_present, cfg_ready;
	logic [3:0] found_x, found_y;
	logic [15:0] item_at_cell;

	grid_result_t pending_results[$];
	table_row_t   directed_rows[$];
	int           errors = 0;
	bit           burst = 1'b0;

	// shadow of the allocator state
	logic [4:0]  grid_w, grid_h;
	logic        occ[16][16];
	logic [15:0] origin_id[16][16];
	logic        origin_vld[16][16];

	grid_rectangle_occupancy_allocator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.opcode(opcode), .pos_x(pos_x), .pos_y(pos_y), .span_x(span_x),
		.span_y(span_y), .item_id(item_id), .done(done), .ok(ok),
		.found_x(found_x), .found_y(found_y), .item_present(item_present),
		.item_at_cell(item_at_cell), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int act_w();
		return grid_w < 16 ? int'(grid_w) : 16;
	endfunction

	function automatic int act_h();
		return grid_h < 16 ? int'(grid_h) : 16;
	endfunction

	function automatic bit rect_fits(int x, int y, int sx, int sy);
		if (x >= act_w() || y >= act_h() || occ[y][x])
			return 1'b0;
		if (sx == 0 || sy == 0)
			return 1'b1;
		if (x + sx > act_w() || y + sy > act_h())
			return 1'b0;
		for (int j = 0; j < sy; j++)
			for (int i = 0; i < sx; i++)
				if (occ[y + j][x + i])
					return 1'b0;
		return 1'b1;
	endfunction

	function automatic void paint_rect(int x, int y, int sx, int sy, logic v);
		for (int j = 0; j < sy; j++)
			for (int i = 0; i < sx; i++)
				if (x + i < act_w() && y + j < act_h())
					occ[y + j][x + i] = v;
	endfunction

	// apply one command to the shadow state and return its result
	function automatic grid_result_t allocate_step(grid_cmd_t c);
		grid_result_t r;
		int x, y, sx, sy;
		bit hit;
		r = '0;
		x = int'(c.px);
		y = int'(c.py);
		sx = int'(c.sx);
		sy = int'(c.sy);
		hit = 1'b0;
		case (c.op)
			groa_pkg::OP_FIT: r.ok = rect_fits(x, y, sx, sy);
			groa_pkg::OP_FIND: begin
				for (int j = 0; j < act_h() && !hit; j++)
					for (int i = 0; i < act_w() && !hit; i++)
						if (rect_fits(i, j, sx, sy)) begin
							hit = 1'b1;
							r.ok = 1'b1;
							r.fx = i[3:0];
							r.fy = j[3:0];
						end
			end
			groa_pkg::OP_MARK: begin
				paint_rect(x, y, sx, sy, 1'b1);
				origin_id[y][x] = c.id;
				origin_vld[y][x] = 1'b1;
				r.ok = 1'b1;
			end
			groa_pkg::OP_UNMARK: begin
				paint_rect(x, y, sx, sy, 1'b0);
				origin_vld[y][x] = 1'b0;
				r.ok = 1'b1;
			end
			groa_pkg::OP_REPLACE: begin
				if (origin_vld[y][x] && x < act_w() && y < act_h()) begin
					if (sx == 0 || sy == 0)
						r.ok = !occ[y][x];
					else
						r.ok = (x + sx <= act_w()) && (y + sy <= act_h());
				end
			end
			groa_pkg::OP_QUERY: begin
				if (origin_vld[y][x]) begin
					r.pres = 1'b1;
					r.item = origin_id[y][x];
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic grid_result_t res(logic o, int fx, int fy, logic p, int it);
		grid_result_t r;
		r.ok = o;
		r.fx = fx[3:0];
		r.fy = fy[3:0];
		r.pres = p;
		r.item = it[15:0];
		return r;
	endfunction

	function automatic void add_row(groa_pkg::op_t op, int x, int y, int sx, int sy, int id,
			bit typed, grid_result_t r);
		table_row_t t;
		t.cmd = {op, x[3:0], y[3:0], sx[4:0], sy[4:0], id[15:0]};
		t.typed = typed;
		t.res = r;
		directed_rows.push_back(t);
	endfunction

	// drive one command, hold until accepted, then queue its expected result
	task automatic send_cmd(grid_cmd_t c, bit typed, grid_result_t r);
		int gap;
		grid_result_t p;
		gap = burst ? 0 : int'($urandom_range(0, 13));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		opcode <= c.op;
		pos_x <= c.px;
		pos_y <= c.py;
		span_x <= c.sx;
		span_y <= c.sy;
		item_id <= c.id;
		do @(posedge clk); while (busy);
		p = allocate_step(c);
		pending_results.push_back(typed ? r : p);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_grid(int w, int h);
		cfg_valid <= 1'b1;
		cfg_index <= groa_pkg::CFG_GRID_WIDTH;
		cfg_data <= w[4:0];
		do @(posedge clk); while (!cfg_ready);
		grid_w = w[4:0];
		cfg_index <= groa_pkg::CFG_GRID_HEIGHT;
		cfg_data <= h[4:0];
		do @(posedge clk); while (!cfg_ready);
		grid_h = h[4:0];
		cfg_valid <= 1'b0;
	endtask

	function automatic grid_cmd_t random_cmd();
		grid_cmd_t c;
		c.op = groa_pkg::op_t'($urandom_range(0, 5));
		if ($urandom_range(0, 9) < 8) begin
			c.px = 4'($urandom_range(0, act_w() - 1));
			c.py = 4'($urandom_range(0, act_h() - 1));
		end else begin
			c.px = 4'($urandom_range(0, 15));
			c.py = 4'($urandom_range(0, 15));
		end
		case ($urandom_range(0, 9))
			0: c.sx = 5'd0;
			1: c.sx = 5'($urandom_range(0, 16));
			default: c.sx = 5'($urandom_range(1, 4));
		endcase
		case ($urandom_range(0, 9))
			0: c.sy = 5'd0;
			1: c.sy = 5'($urandom_range(0, 16));
			default: c.sy = 5'($urandom_range(1, 4));
		endcase
		c.id = 16'($urandom_range(0, 65535));
		return c;
	endfunction

	// results cannot be stalled: compare every done cycle
	always @(posedge clk) begin
		grid_result_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result with no item outstanding");
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (ok !== e.ok) begin
					$error("ok expected %0d actual %0d", e.ok, ok);
					errors++;
				end
				if (found_x !== e.fx) begin
					$error("found_x expected %0d actual %0d", e.fx, found_x);
					errors++;
				end
				if (found_y !== e.fy) begin
					$error("found_y expected %0d actual %0d", e.fy, found_y);
					errors++;
				end
				if (item_present !== e.pres) begin
					$error("item_present expected %0d actual %0d", e.pres, item_present);
					errors++;
				end
				if (item_at_cell !== e.item) begin
					$error("item_at_cell expected %h actual %h", e.item, item_at_cell);
					errors++;
				end
			end
		end
	end

	initial begin
		#5ms;
		$display("tb_grid_rectangle_occupancy_allocator_unit: errors");
		$finish;
	end

	initial begin
		int sizes_w[6] = '{16, 1, 1, 16, 5, 11};
		int sizes_h[6] = '{16, 1, 16, 1, 7, 3};
		grid_result_t none;
		none = '0;
		grid_w = groa_pkg::GRID_RESET;
		grid_h = groa_pkg::GRID_RESET;
		for (int j = 0; j < 16; j++)
			for (int i = 0; i < 16; i++) begin
				occ[j][i] = 1'b0;
				origin_vld[j][i] = 1'b0;
				origin_id[j][i] = '0;
			end

		add_row(groa_pkg::OP_QUERY, 0, 0, 0, 0, 0, 1, res(0, 0, 0, 0, 0));
		add_row(groa_pkg::OP_FIT, 0, 0, 16, 16, 0, 1, res(1, 0, 0, 0, 0));
		add_row(groa_pkg::OP_FIT, 15, 15, 1, 1, 0, 1, res(1, 0, 0, 0, 0));
		add_row(groa_pkg::OP_FIT, 15, 15, 2, 1, 0, 1, res(0, 0, 0, 0, 0));
		add_row(groa_pkg::OP_FIND, 0, 0, 16, 16, 0, 1, res(1, 0, 0, 0, 0));
		add_row(groa_pkg::OP_MARK, 0, 0, 16, 16, 'hffff, 1, res(1, 0, 0, 0, 0));
		add_row(groa_pkg::OP_FIND, 0, 0, 1, 1, 0, 1, res(0, 0, 0, 0, 0));
		add_row(groa_pkg::OP_QUERY, 0, 0, 0, 0, 0, 1, res(0, 0, 0, 1, 'hffff));
		add_row(groa_pkg::OP_REPLACE, 0, 0, 16, 16, 0, 1, res(1, 0, 0, 0, 0));
		add_row(groa_pkg::OP_REPLACE, 0, 0, 0, 0, 0, 1, res(0, 0, 0, 0, 0));
		add_row(groa_pkg::OP_UNMARK, 0, 0, 16, 16, 0, 1, res(1, 0, 0, 0, 0));
		add_row(groa_pkg::OP_QUERY, 0, 0, 0, 0, 0, 1, res(0, 0, 0, 0, 0));
		// zero span: identifier recorded, no cell painted
		add_row(groa_pkg::OP_MARK, 3, 3, 0, 5, 'h1234, 1, res(1, 0, 0, 0, 0));
		add_row(groa_pkg::OP_QUERY, 3, 3, 0, 0, 0, 1, res(0, 0, 0, 1, 'h1234));
		add_row(groa_pkg::OP_FIT, 3, 3, 0, 0, 0, 1, res(1, 0, 0, 0, 0));
		add_row(groa_pkg::OP_REPLACE, 3, 3, 0, 0, 0, 1, res(1, 0, 0, 0, 0));
		// span running off the grid edge gets clipped
		add_row(groa_pkg::OP_MARK, 14, 14, 5, 5, 'haaaa, 1, res(1, 0, 0, 0, 0));
		add_row(groa_pkg::OP_FIT, 15, 15, 1, 1, 0, 1, res(0, 0, 0, 0, 0));
		add_row(groa_pkg::OP_FIND, 0, 0, 16, 16, 0, 1, res(0, 0, 0, 0, 0));
		add_row(groa_pkg::OP_FIND, 0, 0, 1, 1, 0, 0, none);
		add_row(groa_pkg::OP_REPLACE, 14, 14, 2, 2, 0, 1, res(1, 0, 0, 0, 0));
		add_row(groa_pkg::OP_REPLACE, 14, 14, 3, 1, 0, 1, res(0, 0, 0, 0, 0));
		add_row(groa_pkg::OP_UNMARK, 14, 14, 5, 5, 0, 0, none);
		add_row(groa_pkg::OP_MARK, 7, 8, 1, 1, 'h5555, 0, none);
		add_row(groa_pkg::OP_FIND, 0, 0, 2, 2, 0, 0, none);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k])
			send_cmd(directed_rows[k].cmd, directed_rows[k].typed, directed_rows[k].res);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			set_grid(sizes_w[ph], sizes_h[ph]);
			for (int n = 0; n < 85; n++) begin
				if (n % 20 == 0)
					burst = ($urandom_range(0, 3) == 0);
				send_cmd(random_cmd(), 1'b0, none);
			end
			burst = 1'b0;
			drain();
		end

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb_grid_rectangle_occupancy_allocator_unit: clean");
		else
			$display("tb_grid_rectangle_occupancy_allocator_unit: errors");
		$finish;
	end
endmodule
